// ===== rtl/kfs_pkg.sv =====
package kfs_pkg;

  // field widths
  localparam int REQ_W   = 3;
  localparam int BONE_W  = 5;
  localparam int MOT_W   = 8;
  localparam int TIDX_W  = 12;
  localparam int WORD_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int FRAME_W = 12;
  localparam int PVAL_W  = 8;

  // configuration register widths and port
  localparam int CFG_FRAMES_W = 13;
  localparam int CFG_BONES_W  = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BONES  = 2'd1;

  localparam logic [CFG_FRAMES_W-1:0] CFG_FRAMES_RST = 13'd4096;
  localparam logic [CFG_BONES_W-1:0]  CFG_BONES_RST  = 6'd32;

  // default sizes
  localparam int MAX_BONES_DEF  = 32;
  localparam int MAX_FRAMES_DEF = 4096;
  localparam int MOTIONS_DEF    = 256;
  localparam int PARAM_SLOTS    = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SET_MOTION = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD_FLAG  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOAD_START = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_PARAM = 3'd4;

  // flag word encoding
  localparam int FLAG_ADV_BIT  = 14;
  localparam int FLAG_JUMP_BIT = 15;
  localparam logic [WORD_W-1:0] FLAG_ALL_ONES = 16'hFFFF;
  localparam logic [WORD_W-1:0] START_ABSENT  = 16'hFFFF;

  typedef struct packed {
    logic load_req;
    logic wr_flag;
    logic wr_mst;
    logic idx_clr;
    logic idx_inc;
    logic use_idx;
    logic bone_rd;
    logic rd_next;
    logic cap;
    logic flag_rd_old;
    logic apply_step;
    logic mst_rd;
    logic mot_from_flag;
    logic apply_start;
    logic param_chk;
    logic out_bone;
    logic out_param;
    logic out_last;
    logic chg_clr;
  } cmd_t;

  typedef struct packed {
    logic flag_adv;
    logic flag_jump;
    logic jump_ok;
    logic req_ok;
    logic start_absent;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/keyframe_flag_sequencer_unit.sv =====
// tick: reads each bone and its flag word, the start table when a jump word starts a motion,
//   checks parameters, then gives one result per bone; set motion and read parameter give one
//   result, table loads none; one request at a time, the bone walk sets the rate
// each bone step is bound by the registered reads of the flag and motion start tables
// reset (rst_n low, synchronous): bones at frame 0 motion 0, parameters and changed flag 0,
//   num_frames 4096, num_bones 32; flag and start tables keep their contents, no clearing pass
module keyframe_flag_sequencer_unit #(
  parameter int MAX_BONES  = kfs_pkg::MAX_BONES_DEF,
  parameter int MAX_FRAMES = kfs_pkg::MAX_FRAMES_DEF,
  parameter int MOTIONS    = kfs_pkg::MOTIONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [kfs_pkg::REQ_W-1:0]      in_req_type,
  input  logic [kfs_pkg::BONE_W-1:0]     in_bone_id,
  input  logic [kfs_pkg::MOT_W-1:0]      in_motion_id,
  input  logic [kfs_pkg::TIDX_W-1:0]     in_table_index,
  input  logic [kfs_pkg::WORD_W-1:0]     in_table_word,
  input  logic [kfs_pkg::SLOT_W-1:0]     in_param_slot,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kfs_pkg::BONE_W-1:0]     out_bone,
  output logic [kfs_pkg::FRAME_W-1:0]    out_frame,
  output logic [kfs_pkg::MOT_W-1:0]      out_motion,
  output logic [kfs_pkg::PVAL_W-1:0]     out_param_value,
  output logic                           out_any_changed,
  output logic                           out_last,
  // register writes
  input  logic                           cfg_we,
  input  logic [kfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import kfs_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t st;

  // sequencer: walks the bones, then reports them one transfer per cycle while out_ready holds
  kfs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .st          (st),
    .cmd         (cmd)
  );

  // datapath: bone store, flag and start tables, parameter slots, result register
  kfs_datapath #(
    .MAX_BONES  (MAX_BONES),
    .MAX_FRAMES (MAX_FRAMES),
    .MOTIONS    (MOTIONS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_bone_id      (in_bone_id),
    .in_motion_id    (in_motion_id),
    .in_table_index  (in_table_index),
    .in_table_word   (in_table_word),
    .in_param_slot   (in_param_slot),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bone        (out_bone),
    .out_frame       (out_frame),
    .out_motion      (out_motion),
    .out_param_value (out_param_value),
    .out_any_changed (out_any_changed),
    .out_last        (out_last)
  );

endmodule

// ===== rtl/kfs_ram.sv =====
module kfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/kfs_ctrl.sv =====
module kfs_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kfs_pkg::REQ_W-1:0]    in_req_type,
  input  kfs_pkg::status_t             st,
  output kfs_pkg::cmd_t                cmd
);

  import kfs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_T_RD   = 4'd1;
  localparam logic [3:0] S_T_BONE = 4'd2;
  localparam logic [3:0] S_T_FLAG = 4'd3;
  localparam logic [3:0] S_T_MST  = 4'd4;
  localparam logic [3:0] S_T_PAR  = 4'd5;
  localparam logic [3:0] S_R_RD   = 4'd6;
  localparam logic [3:0] S_R_OUT  = 4'd7;
  localparam logic [3:0] S_M_CHK  = 4'd8;
  localparam logic [3:0] S_M_MST  = 4'd9;
  localparam logic [3:0] S_M_PAR  = 4'd10;
  localparam logic [3:0] S_M_RD   = 4'd11;
  localparam logic [3:0] S_M_OUT  = 4'd12;
  localparam logic [3:0] S_P_OUT  = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd         = '0;
    cmd.use_idx = 1'b1;
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_req = 1'b1;
          unique case (in_req_type)
            REQ_TICK: begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_T_RD;
            end
            REQ_SET_MOTION: state_nxt = S_M_CHK;
            REQ_LOAD_FLAG:  cmd.wr_flag = 1'b1;
            REQ_LOAD_START: cmd.wr_mst = 1'b1;
            REQ_READ_PARAM: state_nxt = S_P_OUT;
            default:        state_nxt = S_IDLE;
          endcase
        end
      end
      S_T_RD: begin
        cmd.bone_rd = 1'b1;
        state_nxt   = S_T_BONE;
      end
      S_T_BONE: begin
        cmd.cap         = 1'b1;
        cmd.flag_rd_old = 1'b1;
        state_nxt       = S_T_FLAG;
      end
      S_T_FLAG: begin
        if (st.flag_adv || !st.flag_jump) begin
          cmd.apply_step = 1'b1;
          state_nxt      = S_T_PAR;
        end else if (st.jump_ok) begin
          cmd.mst_rd        = 1'b1;
          cmd.mot_from_flag = 1'b1;
          state_nxt         = S_T_MST;
        end else if (st.idx_last) begin
          // motion out of range, bone stays
          cmd.idx_clr = 1'b1;
          state_nxt   = S_R_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.bone_rd = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = S_T_BONE;
        end
      end
      S_T_MST: begin
        if (!st.start_absent) begin
          cmd.apply_start = 1'b1;
          state_nxt       = S_T_PAR;
        end else if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_R_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.bone_rd = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = S_T_BONE;
        end
      end
      S_T_PAR: begin
        cmd.param_chk = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_R_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.bone_rd = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = S_T_BONE;
        end
      end
      S_R_RD: begin
        cmd.bone_rd = 1'b1;
        state_nxt   = S_R_OUT;
      end
      S_R_OUT: begin
        if (st.out_free) begin
          cmd.out_bone = 1'b1;
          cmd.out_last = st.idx_last;
          if (st.idx_last) begin
            cmd.chg_clr = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.bone_rd = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      S_M_CHK: begin
        cmd.use_idx = 1'b0;
        if (st.req_ok) begin
          cmd.mst_rd = 1'b1;
          state_nxt  = S_M_MST;
        end else begin
          state_nxt = S_M_RD;
        end
      end
      S_M_MST: begin
        cmd.use_idx = 1'b0;
        if (!st.start_absent) begin
          cmd.apply_start = 1'b1;
          state_nxt       = S_M_PAR;
        end else begin
          state_nxt = S_M_RD;
        end
      end
      S_M_PAR: begin
        cmd.use_idx   = 1'b0;
        cmd.param_chk = 1'b1;
        state_nxt     = S_M_RD;
      end
      S_M_RD: begin
        cmd.use_idx = 1'b0;
        cmd.bone_rd = 1'b1;
        state_nxt   = S_M_OUT;
      end
      S_M_OUT: begin
        cmd.use_idx = 1'b0;
        if (st.out_free) begin
          cmd.out_bone = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_P_OUT: begin
        if (st.out_free) begin
          cmd.out_param = 1'b1;
          cmd.out_last  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/kfs_datapath.sv =====
module kfs_datapath #(
  parameter int MAX_BONES  = 32,
  parameter int MAX_FRAMES = 4096,
  parameter int MOTIONS    = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  kfs_pkg::cmd_t                     cmd,
  output kfs_pkg::status_t                  st,
  input  logic [kfs_pkg::BONE_W-1:0]        in_bone_id,
  input  logic [kfs_pkg::MOT_W-1:0]         in_motion_id,
  input  logic [kfs_pkg::TIDX_W-1:0]        in_table_index,
  input  logic [kfs_pkg::WORD_W-1:0]        in_table_word,
  input  logic [kfs_pkg::SLOT_W-1:0]        in_param_slot,
  input  logic                              cfg_we,
  input  logic [kfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kfs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kfs_pkg::BONE_W-1:0]        out_bone,
  output logic [kfs_pkg::FRAME_W-1:0]       out_frame,
  output logic [kfs_pkg::MOT_W-1:0]         out_motion,
  output logic [kfs_pkg::PVAL_W-1:0]        out_param_value,
  output logic                              out_any_changed,
  output logic                              out_last
);

  import kfs_pkg::*;

  localparam int FW  = $clog2(MAX_FRAMES);
  localparam int BW  = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int MW  = (MOTIONS > 1) ? $clog2(MOTIONS) : 1;
  localparam int BDW = FW + MOT_W;

  // configuration
  logic [CFG_FRAMES_W-1:0] cfg_frames_r;
  logic [CFG_BONES_W-1:0]  cfg_bones_r;
  logic [31:0]             nf32;
  logic [31:0]             nb32;

  // latched request
  logic [BONE_W-1:0] req_bone_r;
  logic [MOT_W-1:0]  req_motion_r;
  logic [SLOT_W-1:0] req_slot_r;

  // walk state
  logic [BW-1:0]     idx_r;
  logic [FW-1:0]     cur_frame_r;
  logic [MOT_W-1:0]  cur_motion_r;
  logic [MOT_W-1:0]  mot_r;
  logic              chg_r;
  logic [PVAL_W-1:0] param_r [PARAM_SLOTS];

  // bone store
  logic [MAX_BONES-1:0] bone_vld_r;
  logic                 bone_vld_q_r;
  logic [BDW-1:0]       bone_rdata;
  logic [BDW-1:0]       bone_rdv;
  logic [BDW-1:0]       bone_wdata;
  logic [BW-1:0]        bone_addr;
  logic [BW-1:0]        bone_raddr;
  logic                 bone_we;
  logic                 bone_re;
  logic [31:0]          req_bone32;
  logic [31:0]          idx_p1_32;
  logic [FW-1:0]        rd_frame;
  logic [MOT_W-1:0]     rd_motion;

  // flag and start tables
  logic [WORD_W-1:0] flag_q;
  logic [WORD_W-1:0] mst_q;
  logic              flag_we;
  logic              flag_re;
  logic [FW-1:0]     flag_raddr;
  logic [31:0]       tidx32;
  logic              mst_we;
  logic [31:0]       mst_wa32;
  logic [MOT_W-1:0]  mot_sel;
  logic [31:0]       mot_sel32;

  // frame arithmetic
  logic [31:0]   old32;
  logic [31:0]   nx32;
  logic [31:0]   w32;
  logic [31:0]   new32;
  logic [31:0]   start32;
  logic [31:0]   startn32;
  logic [FW-1:0] step_new;
  logic [FW-1:0] start_new;

  logic        param_we;
  logic        bone_ok;
  logic        rpt_ok;
  logic [31:0] idx32;
  logic [31:0] rpt_frame32;

  // output register
  logic              out_valid_r;
  logic [BONE_W-1:0] out_bone_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic [MOT_W-1:0]  out_motion_r;
  logic [PVAL_W-1:0] out_pval_r;
  logic              out_chg_r;
  logic              out_last_r;

  // saturated register values
  always_comb begin
    if (cfg_frames_r == '0) begin
      nf32 = 32'd1;
    end else if (32'(cfg_frames_r) > 32'(MAX_FRAMES)) begin
      nf32 = 32'(MAX_FRAMES);
    end else begin
      nf32 = 32'(cfg_frames_r);
    end
    if (cfg_bones_r == '0) begin
      nb32 = 32'd1;
    end else if (32'(cfg_bones_r) > 32'(MAX_BONES)) begin
      nb32 = 32'(MAX_BONES);
    end else begin
      nb32 = 32'(cfg_bones_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= CFG_FRAMES_RST;
      cfg_bones_r  <= CFG_BONES_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_FRAMES) begin
        cfg_frames_r <= cfg_wdata[CFG_FRAMES_W-1:0];
      end else if (cfg_index == CFG_NUM_BONES) begin
        cfg_bones_r <= cfg_wdata[CFG_BONES_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_bone_r   <= in_bone_id;
      req_motion_r <= in_motion_id;
      req_slot_r   <= in_param_slot;
    end
  end

  // bone addressing
  assign req_bone32 = 32'(req_bone_r);
  assign idx32      = 32'(idx_r);
  assign idx_p1_32  = idx32 + 32'd1;
  assign bone_addr  = cmd.use_idx ? idx_r : req_bone32[BW-1:0];
  assign bone_raddr = cmd.rd_next ? idx_p1_32[BW-1:0] : bone_addr;
  assign bone_re    = cmd.bone_rd;
  assign bone_we    = cmd.apply_step || cmd.apply_start;
  assign bone_rdv   = bone_vld_q_r ? bone_rdata : '0;
  assign rd_frame   = bone_rdv[FW-1:0];
  assign rd_motion  = bone_rdv[BDW-1:FW];
  assign bone_wdata = cmd.apply_start ? {mot_r, start_new} : {cur_motion_r, step_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_p1_32[BW-1:0];
    end
  end

  // entries never written read as frame 0, motion 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bone_vld_r   <= '0;
      bone_vld_q_r <= 1'b0;
    end else begin
      if (bone_we) begin
        bone_vld_r[bone_addr] <= 1'b1;
      end
      if (bone_re) begin
        bone_vld_q_r <= bone_vld_r[bone_raddr];
      end
    end
  end

  kfs_ram #(
    .WIDTH (BDW),
    .DEPTH (MAX_BONES)
  ) u_bone_ram (
    .clk   (clk),
    .we    (bone_we),
    .waddr (bone_addr),
    .wdata (bone_wdata),
    .re    (bone_re),
    .raddr (bone_raddr),
    .rdata (bone_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cur_frame_r  <= rd_frame;
      cur_motion_r <= rd_motion;
    end
  end

  // next frame for advance and goto words, and start frame for jump words
  always_comb begin
    old32 = 32'(cur_frame_r);
    nx32  = old32 + 32'd1;
    w32   = 32'(flag_q);
    if (flag_q[FLAG_ADV_BIT]) begin
      new32 = (nx32 >= nf32) ? 32'd0 : nx32;
    end else begin
      new32 = (w32 >= nf32) ? 32'd0 : w32;
    end
    start32  = 32'(mst_q);
    startn32 = (start32 >= nf32) ? 32'd0 : start32;
  end

  assign step_new  = new32[FW-1:0];
  assign start_new = startn32[FW-1:0];

  // flag table
  assign tidx32     = 32'(in_table_index);
  assign flag_we    = cmd.wr_flag && (tidx32 < 32'(MAX_FRAMES));
  assign flag_re    = cmd.flag_rd_old || cmd.apply_step || cmd.apply_start;
  assign flag_raddr = cmd.apply_step ? step_new : (cmd.apply_start ? start_new : rd_frame);

  kfs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_FRAMES)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (tidx32[FW-1:0]),
    .wdata (in_table_word),
    .re    (flag_re),
    .raddr (flag_raddr),
    .rdata (flag_q)
  );

  // motion start table
  assign mst_wa32  = 32'(in_motion_id);
  assign mst_we    = cmd.wr_mst && (mst_wa32 < 32'(MOTIONS));
  assign mot_sel   = cmd.mot_from_flag ? flag_q[MOT_W-1:0] : req_motion_r;
  assign mot_sel32 = 32'(mot_sel);

  kfs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MOTIONS)
  ) u_start_ram (
    .clk   (clk),
    .we    (mst_we),
    .waddr (mst_wa32[MW-1:0]),
    .wdata (in_table_word),
    .re    (cmd.mst_rd),
    .raddr (mot_sel32[MW-1:0]),
    .rdata (mst_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.mst_rd) begin
      mot_r <= mot_sel;
    end
  end

  // parameter slots, written by parameter-set words on the new frame
  assign param_we = cmd.param_chk && flag_q[FLAG_ADV_BIT] && (flag_q != FLAG_ALL_ONES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PARAM_SLOTS; i++) begin
        param_r[i] <= '0;
      end
    end else if (param_we) begin
      param_r[flag_q[11:8]] <= flag_q[PVAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_r <= 1'b0;
    end else if (cmd.chg_clr) begin
      chg_r <= 1'b0;
    end else if (cmd.apply_start) begin
      chg_r <= 1'b1;
    end else if (cmd.apply_step && (step_new != cur_frame_r)) begin
      chg_r <= 1'b1;
    end
  end

  // status
  assign bone_ok         = req_bone32 < 32'(MAX_BONES);
  assign rpt_ok          = cmd.use_idx || bone_ok;
  assign st.flag_adv     = flag_q[FLAG_ADV_BIT];
  assign st.flag_jump    = flag_q[FLAG_JUMP_BIT];
  assign st.jump_ok      = 32'(flag_q[MOT_W-1:0]) < 32'(MOTIONS);
  assign st.req_ok       = bone_ok && (32'(req_motion_r) < 32'(MOTIONS));
  assign st.start_absent = (mst_q == START_ABSENT);
  assign st.idx_last     = (idx32 == (nb32 - 32'd1));
  assign st.out_free     = !out_valid_r || out_ready;

  // output register
  assign rpt_frame32 = 32'(rd_frame);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_bone || cmd.out_param) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_bone) begin
      out_bone_r   <= cmd.use_idx ? idx32[BONE_W-1:0] : req_bone_r;
      out_frame_r  <= rpt_ok ? rpt_frame32[FRAME_W-1:0] : '0;
      out_motion_r <= rpt_ok ? rd_motion : '0;
      out_pval_r   <= '0;
      out_chg_r    <= chg_r;
      out_last_r   <= cmd.out_last;
    end else if (cmd.out_param) begin
      out_bone_r   <= '0;
      out_frame_r  <= '0;
      out_motion_r <= '0;
      out_pval_r   <= param_r[req_slot_r];
      out_chg_r    <= chg_r;
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bone        = out_bone_r;
  assign out_frame       = out_frame_r;
  assign out_motion      = out_motion_r;
  assign out_param_value = out_pval_r;
  assign out_any_changed = out_chg_r;
  assign out_last        = out_last_r;

`ifndef ASSERT_OFF
  a_bone_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(bone_we && bone_re))
    else $error("bone store read and written in one cycle");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_bone || cmd.out_param) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  a_param_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    param_we |-> $past(flag_re))
    else $error("parameter write without a flag read before it");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.idx_inc |-> !st.idx_last)
    else $error("bone index stepped past the last bone");
`endif

endmodule
